>>> rtl/bdrc_pkg.sv
// Shared widths, register indexes and helper types for the B-dot rate damping block.
// No dependencies; compile this file first.
package bdrc_pkg;

    // Sample and command widths
    localparam int SAMPLE_BITS = 16;
    localparam int SEQ_W       = 32;
    localparam int GAIN_W      = 8;
    localparam int LIMIT_W     = 15;
    localparam int MOMENT_W    = 16;
    localparam int MAG_W       = MOMENT_W - 1;
    localparam int COUNT_W     = 32;
    localparam int AXES        = 3;

    // Difference and product widths: the product never overflows
    localparam int DIFF_W = SAMPLE_BITS + 1;
    localparam int PROD_W = DIFF_W + GAIN_W + 1;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = LIMIT_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN  = 1'b0,
        REG_LIMIT = 1'b1
    } cfg_reg_t;

    // Register reset values
    localparam logic [GAIN_W-1:0]  GAIN_RESET  = GAIN_W'(8);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(2000);

    // Clamp mask bit per axis
    localparam int AXIS_X = 0;
    localparam int AXIS_Y = 1;
    localparam int AXIS_Z = 2;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [MOMENT_W-1:0]    moment_t;

endpackage

>>> rtl/bdrc_sample_if.sv
// Input channel: one magnetometer sample word with its sequence number.
// Depends on bdrc_pkg.
interface bdrc_sample_if import bdrc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [SEQ_W-1:0]   sequence_req;
    sample_t            field_x;
    sample_t            field_y;
    sample_t            field_z;

    modport source (output valid, sequence_req, field_x, field_y, field_z, input ready);
    modport sink   (input valid, sequence_req, field_x, field_y, field_z, output ready);
    modport monitor (input valid, ready, sequence_req, field_x, field_y, field_z);
endinterface

>>> rtl/bdrc_result_if.sv
// Output channel: one clamped coil command word with status fields.
// Depends on bdrc_pkg.
interface bdrc_result_if import bdrc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [SEQ_W-1:0]   out_sequence;
    moment_t            moment_x;
    moment_t            moment_y;
    moment_t            moment_z;
    logic [AXES-1:0]    clamp_mask;
    logic [COUNT_W-1:0] clamp_total;
    logic [MAG_W-1:0]   peak_magnitude;

    modport source (output valid, out_sequence, moment_x, moment_y, moment_z, clamp_mask,
                    clamp_total, peak_magnitude, input ready);
    modport sink   (input valid, out_sequence, moment_x, moment_y, moment_z, clamp_mask,
                    clamp_total, peak_magnitude, output ready);
    modport monitor (input valid, ready, out_sequence, moment_x, moment_y, moment_z,
                     clamp_mask, clamp_total, peak_magnitude);
endinterface

>>> rtl/bdot_rate_damping_controller.sv
// A sample word passes through the input register, then the result register, before its
// result word can be taken. Throughput: one word/cycle while the result channel is not stalled.
// The first sample after reset only loads the previous-sample store; no result.
// Reset (rst_n low, asynchronous) clears valids, the primed flag, the stored
// sample and the clamp count, and sets gain to 8 and the limit to 2000.
// Depends on bdrc_pkg, bdrc_sample_if and bdrc_result_if.
module bdot_rate_damping_controller import bdrc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    bdrc_sample_if.sink           sample,
    bdrc_result_if.source         command,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Configuration registers
    logic [GAIN_W-1:0]  gain_reg;
    logic [LIMIT_W-1:0] limit_reg;

    // Input stage
    logic               s1_valid_reg;
    logic [SEQ_W-1:0]   s1_seq_reg;
    sample_t            s1_field_reg [AXES];

    // Block state
    sample_t            last_reg [AXES];
    logic               primed_reg;
    logic [COUNT_W-1:0] clamp_count_reg;
    logic [COUNT_W-1:0] clamp_count_next;

    // Result stage
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [SEQ_W-1:0]   out_seq_reg;
    moment_t            out_moment_reg [AXES];
    logic [AXES-1:0]    out_mask_reg;
    logic [COUNT_W-1:0] out_total_reg;
    logic [MAG_W-1:0]   out_peak_reg;

    // Datapath
    logic signed [DIFF_W-1:0] diff   [AXES];
    logic signed [PROD_W-1:0] prod   [AXES];
    moment_t                  moment [AXES];
    logic [MAG_W-1:0]         mag    [AXES];
    logic signed [PROD_W-1:0] lim_pos;
    logic signed [PROD_W-1:0] lim_neg;
    logic signed [PROD_W-1:0] gain_s;
    logic [AXES-1:0]          mask;
    logic [MAG_W-1:0]         peak;

    // Handshake
    logic in_fire;
    logic out_free;
    logic s1_move;

    assign out_free = !out_valid_reg || command.ready;
    assign s1_move  = s1_valid_reg && (out_free || !primed_reg);
    assign sample.ready = !s1_valid_reg || s1_move;
    assign in_fire  = sample.valid && sample.ready;

    // Take configuration writes; unknown indexes fall through
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg  <= GAIN_RESET;
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_GAIN:  gain_reg  <= cfg_data[GAIN_W-1:0];
                REG_LIMIT: limit_reg <= cfg_data[LIMIT_W-1:0];
                default:   ;
            endcase
        end
    end

    // Capture the incoming sample word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_fire)
            s1_valid_reg <= 1'b1;
        else if (s1_move)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_seq_reg          <= sample.sequence_req;
            s1_field_reg[AXIS_X] <= sample.field_x;
            s1_field_reg[AXIS_Y] <= sample.field_y;
            s1_field_reg[AXIS_Z] <= sample.field_z;
        end
    end

    // Per-axis command: (before - now) * gain, then clamp to +/- limit
    always_comb
    begin
        lim_pos = signed'(PROD_W'(limit_reg));
        lim_neg = -lim_pos;
        gain_s  = signed'(PROD_W'(gain_reg));
        for (int a = 0; a < AXES; a++)
        begin
            diff[a] = DIFF_W'(last_reg[a]) - DIFF_W'(s1_field_reg[a]);
            prod[a] = PROD_W'(diff[a]) * gain_s;
            if (prod[a] > lim_pos)
            begin
                moment[a] = lim_pos[MOMENT_W-1:0];
                mask[a]   = 1'b1;
            end
            else if (prod[a] < lim_neg)
            begin
                moment[a] = lim_neg[MOMENT_W-1:0];
                mask[a]   = 1'b1;
            end
            else
            begin
                moment[a] = prod[a][MOMENT_W-1:0];
                mask[a]   = 1'b0;
            end
            mag[a] = moment[a][MOMENT_W-1] ? MAG_W'(-moment[a]) : moment[a][MAG_W-1:0];
        end
    end

    // Largest magnitude over the three axes
    always_comb
    begin
        peak = mag[AXIS_X];
        if (mag[AXIS_Y] > peak)
            peak = mag[AXIS_Y];
        if (mag[AXIS_Z] > peak)
            peak = mag[AXIS_Z];
    end

    assign clamp_count_next = (|mask) ? clamp_count_reg + COUNT_W'(1) : clamp_count_reg;
    assign out_valid_next   = (s1_move && primed_reg) || (out_valid_reg && !command.ready);

    // Advance the sample store, primed flag, clamp count and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < AXES; a++)
                last_reg[a] <= '0;
            primed_reg      <= 1'b0;
            clamp_count_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (s1_move)
            begin
                for (int a = 0; a < AXES; a++)
                    last_reg[a] <= s1_field_reg[a];
                primed_reg <= 1'b1;
                if (primed_reg)
                    clamp_count_reg <= clamp_count_next;
            end
        end
    end

    // Load the result word
    always_ff @(posedge clk)
    begin
        if (s1_move && primed_reg)
        begin
            out_seq_reg    <= s1_seq_reg;
            for (int a = 0; a < AXES; a++)
                out_moment_reg[a] <= moment[a];
            out_mask_reg   <= mask;
            out_total_reg  <= clamp_count_next;
            out_peak_reg   <= peak;
        end
    end

    assign command.valid          = out_valid_reg;
    assign command.out_sequence   = out_seq_reg;
    assign command.moment_x       = out_moment_reg[AXIS_X];
    assign command.moment_y       = out_moment_reg[AXIS_Y];
    assign command.moment_z       = out_moment_reg[AXIS_Z];
    assign command.clamp_mask     = out_mask_reg;
    assign command.clamp_total    = out_total_reg;
    assign command.peak_magnitude = out_peak_reg;

endmodule

>>> rtl/bdrc_checker.sv
// Port-level checks on the result channel of the B-dot rate damping block,
// bound to the top level. Depends on bdrc_pkg and bdrc_result_if.
module bdrc_checker import bdrc_pkg::*;
(
    input logic           clk,
    input logic           rst_n,
    bdrc_result_if.source command
);

    logic               out_fire;
    logic               seen_reg;
    logic [COUNT_W-1:0] prev_total_reg;
    logic [MAG_W-1:0]   abs_x;
    logic [MAG_W-1:0]   abs_y;
    logic [MAG_W-1:0]   abs_z;

    assign out_fire = command.valid && command.ready;

    assign abs_x = command.moment_x[MOMENT_W-1] ? MAG_W'(-command.moment_x)
                                                : command.moment_x[MAG_W-1:0];
    assign abs_y = command.moment_y[MOMENT_W-1] ? MAG_W'(-command.moment_y)
                                                : command.moment_y[MAG_W-1:0];
    assign abs_z = command.moment_z[MOMENT_W-1] ? MAG_W'(-command.moment_z)
                                                : command.moment_z[MAG_W-1:0];

    // Track the clamp total of the last delivered word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg       <= 1'b0;
            prev_total_reg <= '0;
        end
        else if (out_fire)
        begin
            seen_reg       <= 1'b1;
            prev_total_reg <= command.clamp_total;
        end
    end

    // Result valid stays high while a result word is stalled
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        command.valid && !command.ready |=> command.valid)
        else $error("result valid dropped while stalled");

    // Peak covers every axis
    a_peak_bound: assert property (@(posedge clk) disable iff (!rst_n)
        command.valid |-> (command.peak_magnitude >= abs_x) &&
                          (command.peak_magnitude >= abs_y) &&
                          (command.peak_magnitude >= abs_z))
        else $error("peak magnitude below an axis magnitude");

    // Clamp total advances by one exactly on clamped words
    a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && seen_reg |->
            command.clamp_total == prev_total_reg + COUNT_W'(command.clamp_mask != '0))
        else $error("clamp total step mismatch");

    // Commands stay within the symmetric range
    a_no_min_code: assert property (@(posedge clk) disable iff (!rst_n)
        command.valid |-> (command.moment_x != {1'b1, {MAG_W{1'b0}}}) &&
                          (command.moment_y != {1'b1, {MAG_W{1'b0}}}) &&
                          (command.moment_z != {1'b1, {MAG_W{1'b0}}}))
        else $error("moment outside symmetric range");

endmodule

bind bdot_rate_damping_controller bdrc_checker u_checker
(
    .clk     (clk),
    .rst_n   (rst_n),
    .command (command)
);
